>>> design/htfp_pkg.sv
// ---------------------------------------------------------------------------
// htfp_pkg
// Types, codes and helper functions for the hex text to fixed point block.
// ---------------------------------------------------------------------------
package htfp_pkg;

  // Default digit limits for the integer and fraction parts.
  localparam int INTEGER_DIGITS_DEFAULT  = 8;
  localparam int FRACTION_DIGITS_DEFAULT = 8;

  // Fixed widths of the result fields and the fraction digit counter.
  localparam int WORD_W       = 32;
  localparam int FRAC_NIBBLES = WORD_W / 4;
  localparam int FCNT_W       = 4;

  // Queue between the classifier and the accumulator (power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes used by the classifier.
  localparam logic [7:0] CHAR_POINT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Character classes decided by the front end.
  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_POINT = 2'd1,
    CLS_BAD   = 2'd2
  } char_class_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } char_entry_t;

  // Fill status of the queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Classify one character and give its digit value.
  function automatic char_entry_t classify(input logic [7:0] c, input logic last);
    char_entry_t e;
    logic [7:0]  diff;
    e.cls   = CLS_BAD;
    e.digit = '0;
    e.last  = last;
    diff    = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff    = c - CHAR_ZERO;
      e.cls   = CLS_DIGIT;
      e.digit = diff[3:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      diff    = c - CHAR_UPPER_A;
      e.cls   = CLS_DIGIT;
      e.digit = diff[3:0] + DIGIT_TEN;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      diff    = c - CHAR_LOWER_A;
      e.cls   = CLS_DIGIT;
      e.digit = diff[3:0] + DIGIT_TEN;
    end else if (c == CHAR_POINT) begin
      e.cls = CLS_POINT;
    end
    return e;
  endfunction

endpackage

>>> design/htfp_if.sv
// ---------------------------------------------------------------------------
// htfp_if
// Valid/ready channel interfaces for characters in and results out.
// ---------------------------------------------------------------------------

// Character channel: one ASCII character per transaction.
interface htfp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

// Result channel: one converted number per transaction.
interface htfp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] integer_part;
  logic [31:0] fraction_part;
  logic [1:0]  status;

  modport source (output valid, output integer_part, output fraction_part,
                  output status, input ready);
  modport sink   (input valid, input integer_part, input fraction_part,
                  input status, output ready);
endinterface

>>> design/htfp_front.sv
// ---------------------------------------------------------------------------
// htfp_front
// Accepts characters and classifies each one as digit, point or invalid.
// ---------------------------------------------------------------------------
module htfp_front
  import htfp_pkg::*;
(
  htfp_char_if.sink chars,
  input  queue_status_t q_stat,
  output logic          push,
  output char_entry_t   push_entry
);

  // Take a character whenever the queue has room.
  assign chars.ready = !q_stat.full;
  assign push        = chars.valid && !q_stat.full;

  // Decode the character into its class and digit value.
  assign push_entry  = classify(chars.character, chars.is_last);

endmodule

>>> design/htfp_queue.sv
// ---------------------------------------------------------------------------
// htfp_queue
// Short register queue that decouples the classifier from the accumulator.
// ---------------------------------------------------------------------------
module htfp_queue
  import htfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  char_entry_t   push_entry,
  input  logic          pop,
  output logic          pop_valid,
  output char_entry_t   pop_entry,
  output queue_status_t q_stat
);

  char_entry_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QLVL_W-1:0] level;

  assign q_stat.full  = (level == QLVL_W'(QUEUE_DEPTH));
  assign q_stat.empty = (level == '0);
  assign pop_valid    = !q_stat.empty;
  assign pop_entry    = slots[rd_ptr];

  // Pointer and fill level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + QLVL_W'(1);
      end else if (pop && !push) begin
        level <= level - QLVL_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> design/htfp_back.sv
// ---------------------------------------------------------------------------
// htfp_back
// Accumulates classified characters into integer and fraction words and
// registers one result when the last character of a number is processed.
// ---------------------------------------------------------------------------
module htfp_back
  import htfp_pkg::*;
#(
  parameter int INTEGER_DIGITS  = INTEGER_DIGITS_DEFAULT,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  char_entry_t   q_entry,
  output logic          q_pop,
  htfp_result_if.source result
);

  // Any of these top bits set means one more digit would overflow.
  localparam int OVF_SHIFT = 4 * INTEGER_DIGITS - 4;

  logic [WORD_W-1:0] int_acc, int_acc_next;
  logic [WORD_W-1:0] frac_acc, frac_acc_next;
  logic [FCNT_W-1:0] frac_cnt, frac_cnt_next;
  logic              point_seen, point_seen_next;
  status_t           err, err_next;
  logic              take;
  logic              load;
  logic              res_valid;
  logic [WORD_W-1:0] res_int;
  logic [WORD_W-1:0] res_frac;
  status_t           res_status;

  // A last character needs a free result register; others always proceed.
  assign take  = q_valid && (!q_entry.last || !res_valid || result.ready);
  assign q_pop = take;
  assign load  = take && q_entry.last;

  // Next accumulator state for the character at the head of the queue.
  always_comb begin
    int_acc_next    = int_acc;
    frac_acc_next   = frac_acc;
    frac_cnt_next   = frac_cnt;
    point_seen_next = point_seen;
    err_next        = err;
    if (take && err == ST_OK) begin
      unique case (q_entry.cls)
        CLS_POINT: begin
          if (point_seen) begin
            err_next = ST_INVALID;
          end else begin
            point_seen_next = 1'b1;
          end
        end
        CLS_DIGIT: begin
          if (!point_seen) begin
            if ((int_acc >> OVF_SHIFT) != '0) begin
              err_next = ST_OVERFLOW;
            end else begin
              int_acc_next = {int_acc[WORD_W-5:0], q_entry.digit};
            end
          end else if (frac_cnt < FCNT_W'(FRACTION_DIGITS)) begin
            frac_cnt_next = frac_cnt + FCNT_W'(1);
            // The k-th fraction digit fills nibble (FRAC_NIBBLES - k).
            for (int i = 0; i < FRAC_NIBBLES; i++) begin
              if (frac_cnt_next == FCNT_W'(FRAC_NIBBLES - i)) begin
                frac_acc_next[4*i +: 4] = frac_acc[4*i +: 4] | q_entry.digit;
              end
            end
          end
        end
        default: begin
          err_next = ST_INVALID;
        end
      endcase
    end
  end

  // Accumulator registers; the end of a number clears them.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_cnt   <= '0;
      point_seen <= 1'b0;
      err        <= ST_OK;
    end else begin
      int_acc    <= int_acc_next;
      frac_acc   <= frac_acc_next;
      frac_cnt   <= frac_cnt_next;
      point_seen <= point_seen_next;
      err        <= err_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload; an error zeroes both value fields.
  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= err_next;
      res_int    <= (err_next == ST_OK) ? int_acc_next  : '0;
      res_frac   <= (err_next == ST_OK) ? frac_acc_next : '0;
    end
  end

  assign result.valid         = res_valid;
  assign result.integer_part  = res_int;
  assign result.fraction_part = res_frac;
  assign result.status        = res_status;

endmodule

>>> design/hex_text_to_fixed_point.sv
// ---------------------------------------------------------------------------
// hex_text_to_fixed_point
// Converts hexadecimal text with an optional point into 32.32 fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   The chars channel takes one ASCII character per transaction, with
//   is_last set on the final character of a number. Digits 0-9, A-F and a-f
//   are accepted, plus at most one point.
//   The result channel gives one transaction per number: integer_part,
//   fraction_part (unit 2^-32) and status (ok, invalid character, integer
//   overflow). On an error both value fields are zero.
//   Throughput is one character per cycle while chars.ready is high. A last
//   character is written into the classifier queue, and from the queue head
//   the accumulator loads the result register.
//   When the receiver stalls, the result register holds and characters keep
//   flowing until a second last character reaches the accumulator; then the
//   two-entry queue fills and chars.ready drops.
//   Reset is synchronous; it empties the queue, drops the result and clears
//   all accumulators.
// ---------------------------------------------------------------------------
module hex_text_to_fixed_point
  import htfp_pkg::*;
#(
  parameter int INTEGER_DIGITS  = INTEGER_DIGITS_DEFAULT,
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  htfp_char_if.sink     chars,
  htfp_result_if.source result
);

  logic          push;
  char_entry_t   push_entry;
  logic          pop;
  logic          pop_valid;
  char_entry_t   pop_entry;
  queue_status_t q_stat;

  // Classifier front end.
  htfp_front u_front (
    .chars      (chars),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decoupling queue.
  htfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // Accumulator back end.
  htfp_back #(
    .INTEGER_DIGITS  (INTEGER_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_entry (pop_entry),
    .q_pop   (pop),
    .result  (result)
  );

  // An error result never carries a value.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_OK) |->
      (result.integer_part == '0 && result.fraction_part == '0))
    else $error("error result carries a nonzero value");

  // The queue is never reported full and empty at once.
  assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // Right after reset the queue is empty, so characters are taken.
  assert property (@(posedge clk) $fell(rst) |-> chars.ready)
    else $error("not ready after reset");

  // Nothing is popped from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule
